[hdl/compacting_region_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the compacting region allocator.
// Each macro checks one property on clk with rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef COMPACTING_REGION_ALLOCATOR_UNIT_MACROS_SVH
`define COMPACTING_REGION_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define CRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define CRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRA_ASSERT_IMP(lbl, ante, cons, msg)
`define CRA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/cra_pkg.sv]
// ----------------------------------------------------------------------------
// cra_pkg
// Shared types, codes and defaults of the compacting region allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cra_pkg;

    // Default table depth and per-entry tracker overhead in bytes.
    localparam int DEF_ENTRIES       = 16;
    localparam int DEF_TRACKER_BYTES = 16;

    // Field widths.
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 31;

    // Configuration register indexes.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_BASE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_CAP  = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_MOVE  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OOM     = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;

    // Request operation codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // One result item.
    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_address;
        logic [ADDR_W-1:0] move_source;
        logic [ADDR_W-1:0] move_dest;
        logic [LEN_W-1:0]  move_length;
        logic              last;
    } result_t;

    // Operands for the shared adder.
    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } alu_req_t;

    // Adder outcome: wrapped sum or difference, and signed a > b.
    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic              gt;
    } alu_rsp_t;

endpackage

[hdl/cra_alu.sv]
// ----------------------------------------------------------------------------
// cra_alu
// Shared 32-bit add/subtract unit with a signed greater-than compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cra_alu
    import cra_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ADDR_W-1:0] b_eff;

    // Two's complement subtract by inverting b and adding one.
    assign b_eff   = req.sub ? ~req.b : req.b;
    assign rsp.sum = req.a + b_eff + {{(ADDR_W-1){1'b0}}, req.sub};

    // Signed compare of the raw operands.
    assign rsp.gt = $signed(req.a) > $signed(req.b);

endmodule

[hdl/cra_table.sv]
// ----------------------------------------------------------------------------
// cra_table
// Entry memory holding the offset and length of each tracked block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cra_table
    import cra_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    localparam int IDX_W  = $clog2(ENTRIES)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic [ADDR_W-1:0] wr_off,
    input  logic [LEN_W-1:0]  wr_len,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic [ADDR_W-1:0] rd_off,
    output logic [LEN_W-1:0]  rd_len
);

    logic [ADDR_W-1:0] off_mem [ENTRIES];
    logic [LEN_W-1:0]  len_mem [ENTRIES];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            off_mem[wr_idx] <= wr_off;
            len_mem[wr_idx] <= wr_len;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_off <= off_mem[rd_idx];
        rd_len <= len_mem[rd_idx];
    end

endmodule

[hdl/compacting_region_allocator_unit.sv]
// ----------------------------------------------------------------------------
// compacting_region_allocator_unit
// Bump allocator over one region with compaction, free and move commands.
// ----------------------------------------------------------------------------
// The block takes one request at a time and is not ready until its last
// result is loaded into the output register. Table entries live in a memory
// with one read and one write port, and all address arithmetic goes through
// one shared 32-bit adder, so the cost per request follows the entries it
// touches. An allocate that fits reads the newest entry, finds the offset,
// subtracts tracker overhead and the request from the capacity, checks the
// fit, appends the entry and forms the address (no read on an empty table).
// A free searches the entries one by one, then shifts later entries down. A
// failed allocate adds a compaction pass, one move command per moved entry,
// and a second fit attempt. Each result waits for the output register to drain.
`timescale 1ns / 1ps
`include "compacting_region_allocator_unit_macros.svh"

module compacting_region_allocator_unit
    import cra_pkg::*;
#(
    parameter int ENTRIES       = DEF_ENTRIES,
    parameter int TRACKER_BYTES = DEF_TRACKER_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,

    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    // Request channel.
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [LEN_W-1:0]  alloc_size,
    input  logic [ADDR_W-1:0] free_address,

    // Result channel.
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        kind,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] result_address,
    output logic [ADDR_W-1:0] move_source,
    output logic [ADDR_W-1:0] move_dest,
    output logic [LEN_W-1:0]  move_length,
    output logic              last
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [19:0] {
        ST_IDLE      = 20'h00001,
        ST_TRY_RD    = 20'h00002,
        ST_TRY_OFF   = 20'h00004,
        ST_RHS_CAP   = 20'h00008,
        ST_RHS_SIZE  = 20'h00010,
        ST_LHS       = 20'h00020,
        ST_FIT       = 20'h00040,
        ST_ADDR      = 20'h00080,
        ST_PACK_RD0  = 20'h00100,
        ST_PACK_END0 = 20'h00200,
        ST_PACK_RD   = 20'h00400,
        ST_PACK_CHK  = 20'h00800,
        ST_PACK_SRC  = 20'h01000,
        ST_PACK_DST  = 20'h02000,
        ST_PACK_NEXT = 20'h04000,
        ST_FREE_RD   = 20'h08000,
        ST_FREE_CHK  = 20'h10000,
        ST_SHIFT_RD  = 20'h20000,
        ST_SHIFT_WR  = 20'h40000,
        ST_EMIT      = 20'h80000
    } state_t;

    // Control registers.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              retry_reg, retry_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [LEN_W-1:0]  cap_reg, cap_next;

    // Working registers.
    logic              func_reg;
    logic [LEN_W-1:0]  size_reg;
    logic [ADDR_W-1:0] faddr_reg;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [ADDR_W-1:0] tmp_reg, tmp_next;
    logic [ADDR_W-1:0] lhs_reg, lhs_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] cur_off_reg, cur_off_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] tb_reg;
    result_t           pend_reg, pend_next;
    result_t           out_reg;

    // Table and adder connections.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [ADDR_W-1:0] wr_off;
    logic [LEN_W-1:0]  wr_len;
    logic [IDX_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_off;
    logic [LEN_W-1:0]  rd_len;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    logic              accept;
    logic              cfg_wr;
    logic              out_load;
    logic              fail;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  idx_p1;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign idx_p1   = idx_reg + CNT_W'(1);

    cra_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_idx (wr_idx),
        .wr_off (wr_off),
        .wr_len (wr_len),
        .rd_idx (rd_idx),
        .rd_off (rd_off),
        .rd_len (rd_len)
    );

    cra_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        base_next = base_reg;
        cap_next  = cap_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_BASE: base_next = pwdata;
                REG_CAP:  cap_next  = pwdata[LEN_W-1:0];
                default:  base_next = base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BASE: prdata = base_reg;
            REG_CAP:  prdata = {1'b0, cap_reg};
            default:  prdata = '0;
        endcase
    end

    // Sequencer: drives the table, the shared adder and the working registers.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        retry_next   = retry_reg;
        off_next     = off_reg;
        tmp_next     = tmp_reg;
        lhs_next     = lhs_reg;
        end_next     = end_reg;
        cur_off_next = cur_off_reg;
        cur_len_next = cur_len_reg;
        src_next     = src_reg;
        pend_next    = pend_reg;
        wr_en        = 1'b0;
        wr_idx       = idx_reg[IDX_W-1:0];
        wr_off       = rd_off;
        wr_len       = rd_len;
        rd_idx       = idx_reg[IDX_W-1:0];
        alu_req      = '0;
        fail         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    retry_next = 1'b0;
                    state_next = (func == FUNC_FREE) ? ST_FREE_RD : ST_TRY_RD;
                end
            end

            // Fetch the newest entry to find where the block would go.
            ST_TRY_RD:
            begin
                rd_idx = cnt_m1[IDX_W-1:0];
                if (count_reg >= CNT_W'(ENTRIES))
                begin
                    fail = 1'b1;
                end
                else if (count_reg == '0)
                begin
                    off_next   = '0;
                    state_next = ST_RHS_CAP;
                end
                else
                begin
                    state_next = ST_TRY_OFF;
                end
            end

            ST_TRY_OFF:
            begin
                alu_req.a  = rd_off;
                alu_req.b  = {1'b0, rd_len};
                off_next   = alu_rsp.sum;
                state_next = ST_RHS_CAP;
            end

            // Room left: capacity minus tracker overhead minus the request.
            ST_RHS_CAP:
            begin
                alu_req.a   = {1'b0, cap_reg};
                alu_req.b   = tb_reg;
                alu_req.sub = 1'b1;
                tmp_next    = alu_rsp.sum;
                state_next  = ST_RHS_SIZE;
            end

            ST_RHS_SIZE:
            begin
                alu_req.a   = tmp_reg;
                alu_req.b   = {1'b0, size_reg};
                alu_req.sub = 1'b1;
                tmp_next    = alu_rsp.sum;
                state_next  = ST_LHS;
            end

            ST_LHS:
            begin
                alu_req.a   = off_reg;
                alu_req.b   = ADDR_W'(1);
                alu_req.sub = 1'b1;
                lhs_next    = alu_rsp.sum;
                state_next  = ST_FIT;
            end

            // Signed fit check; on success append the entry.
            ST_FIT:
            begin
                alu_req.a = lhs_reg;
                alu_req.b = tmp_reg;
                if (alu_rsp.gt)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_idx     = count_reg[IDX_W-1:0];
                    wr_off     = off_reg;
                    wr_len     = size_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_ADDR;
                end
            end

            ST_ADDR:
            begin
                alu_req.a                = base_reg;
                alu_req.b                = off_reg;
                pend_next                = '0;
                pend_next.kind           = KIND_ALLOC;
                pend_next.status         = STAT_OK;
                pend_next.result_address = alu_rsp.sum;
                pend_next.last           = 1'b1;
                state_next               = ST_EMIT;
            end

            // Compaction: the first entry stays, the end of it seeds the walk.
            ST_PACK_RD0:
            begin
                rd_idx     = '0;
                state_next = ST_PACK_END0;
            end

            ST_PACK_END0:
            begin
                alu_req.a  = rd_off;
                alu_req.b  = {1'b0, rd_len};
                end_next   = alu_rsp.sum;
                idx_next   = CNT_W'(1);
                state_next = ST_PACK_RD;
            end

            ST_PACK_RD:
            begin
                state_next = ST_PACK_CHK;
            end

            // Move the entry down when it does not already sit at the end.
            ST_PACK_CHK:
            begin
                cur_off_next = rd_off;
                cur_len_next = rd_len;
                if (rd_off == end_reg)
                begin
                    state_next = ST_PACK_NEXT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_off     = end_reg;
                    wr_len     = rd_len;
                    state_next = ST_PACK_SRC;
                end
            end

            ST_PACK_SRC:
            begin
                alu_req.a  = base_reg;
                alu_req.b  = cur_off_reg;
                src_next   = alu_rsp.sum;
                state_next = ST_PACK_DST;
            end

            ST_PACK_DST:
            begin
                alu_req.a             = base_reg;
                alu_req.b             = end_reg;
                pend_next             = '0;
                pend_next.kind        = KIND_MOVE;
                pend_next.status      = STAT_OK;
                pend_next.move_source = src_reg;
                pend_next.move_dest   = alu_rsp.sum;
                pend_next.move_length = cur_len_reg;
                pend_next.last        = 1'b0;
                state_next            = ST_EMIT;
            end

            ST_PACK_NEXT:
            begin
                alu_req.a = end_reg;
                alu_req.b = {1'b0, cur_len_reg};
                end_next  = alu_rsp.sum;
                idx_next  = idx_p1;
                if (idx_p1 == count_reg)
                begin
                    retry_next = 1'b1;
                    state_next = ST_TRY_RD;
                end
                else
                begin
                    state_next = ST_PACK_RD;
                end
            end

            // Free: linear search for the absolute address.
            ST_FREE_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    pend_next        = '0;
                    pend_next.kind   = KIND_FREE;
                    pend_next.status = STAT_UNKNOWN;
                    pend_next.last   = 1'b1;
                    state_next       = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FREE_CHK;
                end
            end

            ST_FREE_CHK:
            begin
                alu_req.a = base_reg;
                alu_req.b = rd_off;
                if (alu_rsp.sum == faddr_reg)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = ST_FREE_RD;
                end
            end

            // Close the gap by copying each later entry down by one.
            ST_SHIFT_RD:
            begin
                rd_idx = idx_p1[IDX_W-1:0];
                if (idx_p1 == count_reg)
                begin
                    count_next       = cnt_m1;
                    pend_next        = '0;
                    pend_next.kind   = KIND_FREE;
                    pend_next.status = STAT_OK;
                    pend_next.last   = 1'b1;
                    state_next       = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_p1;
                state_next = ST_SHIFT_RD;
            end

            // Hand the pending result to the output register.
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = pend_reg.last ? ST_IDLE : ST_PACK_NEXT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A failed fit compacts once (with fewer than two entries it just retries), then reports out of memory.
        if (fail)
        begin
            if (retry_reg)
            begin
                pend_next        = '0;
                pend_next.kind   = KIND_ALLOC;
                pend_next.status = STAT_OOM;
                pend_next.last   = 1'b1;
                state_next       = ST_EMIT;
            end
            else if (count_reg >= CNT_W'(2))
            begin
                state_next = ST_PACK_RD0;
            end
            else
            begin
                retry_next = 1'b1;
                state_next = ST_TRY_RD;
            end
        end
    end

    // Output valid tracking.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            retry_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            cap_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            retry_reg     <= retry_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
            cap_reg       <= cap_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            size_reg  <= alloc_size;
            faddr_reg <= free_address;
        end
        if (out_load)
        begin
            out_reg <= pend_reg;
        end
        off_reg     <= off_next;
        tmp_reg     <= tmp_next;
        lhs_reg     <= lhs_next;
        end_reg     <= end_next;
        cur_off_reg <= cur_off_next;
        cur_len_reg <= cur_len_next;
        src_reg     <= src_next;
        pend_reg    <= pend_next;
        tb_reg      <= ADDR_W'(TRACKER_BYTES) * (ADDR_W'(count_reg) + ADDR_W'(2));
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign status         = out_reg.status;
    assign result_address = out_reg.result_address;
    assign move_source    = out_reg.move_source;
    assign move_dest      = out_reg.move_dest;
    assign move_length    = out_reg.move_length;
    assign last           = out_reg.last;

    // The table never holds more entries than it has room for.
    `CRA_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(ENTRIES), "entry count overflow")
    // After a request is taken the block is busy and not ready.
    `CRA_ASSERT_NXT(a_busy_after_accept, accept, !in_ready, "ready right after accept")
    // The table is only written while a request is in progress.
    `CRA_ASSERT_IMP(a_no_idle_write, wr_en, state_reg != ST_IDLE, "table write while idle")
    // A move command is never the final result of a request.
    `CRA_ASSERT_IMP(a_move_not_last, out_valid && (kind == KIND_MOVE), !last, "move marked last")
    // A free request only produces free answers.
    `CRA_ASSERT_IMP(a_free_kind, out_load && (func_reg == FUNC_FREE),
                    pend_reg.kind == KIND_FREE, "free request gave wrong kind")

endmodule
